>>> rtl/aesrt_pkg.sv
// Package: AES round transform types, S-box tables and GF(2^8) helpers.
`default_nettype none
package aesrt_pkg;

    localparam int NumBytes = 16;
    localparam int NumCols  = 4;

    localparam logic [2:0] CMD_LOAD      = 3'd0;
    localparam logic [2:0] CMD_ADD_KEY   = 3'd1;
    localparam logic [2:0] CMD_SUB       = 3'd2;
    localparam logic [2:0] CMD_INV_SUB   = 3'd3;
    localparam logic [2:0] CMD_SHIFT     = 3'd4;
    localparam logic [2:0] CMD_INV_SHIFT = 3'd5;
    localparam logic [2:0] CMD_MIX       = 3'd6;
    localparam logic [2:0] CMD_INV_MIX   = 3'd7;

    typedef logic [7:0] t_byte;
    typedef t_byte [3:0] t_col;

    // lane results for one column
    typedef struct packed {
        t_col sub;
        t_col inv_sub;
        t_col mix;
        t_col inv_mix;
    } t_lane_res;

    function automatic t_byte xtime(input t_byte a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_byte gf_mul(input t_byte a, input t_byte b);
        t_byte x;
        t_byte acc;
        x   = a;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ x;
            x = xtime(x);
        end
        gf_mul = acc;
    endfunction

    localparam t_byte SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam t_byte INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

endpackage
`default_nettype wire

>>> rtl/aesrt_lane.sv
// Column lane: S-box, inverse S-box, MixColumns and inverse MixColumns on one column.
`default_nettype none
module aesrt_lane (
    input  wire aesrt_pkg::t_col      i_col,
    output aesrt_pkg::t_lane_res      o_res
);

    localparam aesrt_pkg::t_byte FWD [4] = '{8'd2, 8'd3, 8'd1, 8'd1};
    localparam aesrt_pkg::t_byte INV [4] = '{8'd14, 8'd11, 8'd13, 8'd9};

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            o_res.sub[r]     = aesrt_pkg::SBOX[i_col[r]];
            o_res.inv_sub[r] = aesrt_pkg::INV_SBOX[i_col[r]];
            o_res.mix[r]     = 8'h00;
            o_res.inv_mix[r] = 8'h00;
            for (int k = 0; k < 4; k++) begin
                o_res.mix[r]     = o_res.mix[r]
                                 ^ aesrt_pkg::gf_mul(FWD[(k - r) & 3], i_col[k]);
                o_res.inv_mix[r] = o_res.inv_mix[r]
                                 ^ aesrt_pkg::gf_mul(INV[(k - r) & 3], i_col[k]);
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/aes_round_transform_unit_core.sv
// Top level: AES state register, four column lanes and the merge/select stage.
//
//  channel | dir | handshake          | payload
//  in      | in  | i_valid / o_ready  | i_command, i_data_hi, i_data_lo
//  out     | out | o_valid / i_ready  | o_state_hi, o_state_lo
//
// One word per cycle while the output is not stalled; each command finishes
// in the cycle it is accepted, the new state lands in the state and output
// registers together. The four column lanes set the combinational depth.
// Reset clears the state to zero and empties the output register.
// A new word is taken while the output is empty or being taken this cycle.
`default_nettype none
module aes_round_transform_unit_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [2:0]  i_command,
    input  wire  [63:0] i_data_hi,
    input  wire  [63:0] i_data_lo,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [63:0] o_state_hi,
    output logic [63:0] o_state_lo
);

    logic [127:0] r_state, n_state;
    logic [127:0] r_out;
    logic         r_valid;
    logic [127:0] w_data;
    logic         w_take;
    aesrt_pkg::t_col      w_col [aesrt_pkg::NumCols];
    aesrt_pkg::t_lane_res w_res [aesrt_pkg::NumCols];
    aesrt_pkg::t_byte     w_b   [aesrt_pkg::NumBytes];

    assign w_data  = {i_data_hi, i_data_lo};
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign w_take  = i_valid && o_ready;

    // byte i at bits 127-8i
    always_comb begin
        for (int i = 0; i < aesrt_pkg::NumBytes; i++)
            w_b[i] = r_state[127 - 8 * i -: 8];
        for (int c = 0; c < aesrt_pkg::NumCols; c++)
            for (int r = 0; r < 4; r++)
                w_col[c][r] = w_b[r + 4 * c];
    end

    for (genvar g = 0; g < aesrt_pkg::NumCols; g++) begin : g_lane
        aesrt_lane u_lane (.i_col(w_col[g]), .o_res(w_res[g]));
    end

    // merge the lane outputs and pick by command
    always_comb begin
        n_state = r_state;
        unique case (i_command)
            aesrt_pkg::CMD_LOAD:    n_state = w_data;
            aesrt_pkg::CMD_ADD_KEY: n_state = r_state ^ w_data;
            aesrt_pkg::CMD_SUB, aesrt_pkg::CMD_INV_SUB,
            aesrt_pkg::CMD_MIX, aesrt_pkg::CMD_INV_MIX: begin
                for (int c = 0; c < aesrt_pkg::NumCols; c++)
                    for (int r = 0; r < 4; r++)
                        n_state[127 - 8 * (r + 4 * c) -: 8] =
                            (i_command == aesrt_pkg::CMD_SUB)     ? w_res[c].sub[r] :
                            (i_command == aesrt_pkg::CMD_INV_SUB) ? w_res[c].inv_sub[r] :
                            (i_command == aesrt_pkg::CMD_MIX)     ? w_res[c].mix[r] :
                                                                    w_res[c].inv_mix[r];
            end
            aesrt_pkg::CMD_SHIFT, aesrt_pkg::CMD_INV_SHIFT: begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        n_state[127 - 8 * (r + 4 * c) -: 8] =
                            (i_command == aesrt_pkg::CMD_SHIFT)
                                ? w_b[r + 4 * ((c + r) & 3)]
                                : w_b[r + 4 * ((c + 4 - r) & 3)];
            end
            default: n_state = r_state;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_state <= n_state;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_out <= n_state;
    end

    assign o_state_hi = r_out[127:64];
    assign o_state_lo = r_out[63:0];

    a_out_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_out == r_state))
        else $error("output word differs from held state");

    a_take_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_valid)
        else $error("accepted word not presented");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_take |=> $stable(r_state))
        else $error("state moved without an accepted word");

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Testbench for the AES round transform unit: queued driver, monitor and state predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 200000;

    typedef struct {
        logic [2:0]  command;
        logic [63:0] data_hi;
        logic [63:0] data_lo;
    } t_word;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_state_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_command = aesrt_pkg::CMD_LOAD;
    logic [63:0] i_data_hi = '0;
    logic [63:0] i_data_lo = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_state_hi;
    logic [63:0] o_state_lo;

    aes_round_transform_unit_core uut (.*);

    t_word            cmd_queue[$];
    t_state_word      expected_states[$];
    aesrt_pkg::t_byte model_state[16];
    int               error_count = 0;
    int               cycle_count = 0;
    int               words_sent = 0;
    int               states_checked = 0;
    int               cmd_hits[8];
    int               send_gap = 0;
    int               recv_gap = 0;
    bit               drain_hold = 1'b0;
    bit               accepted_last = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic aesrt_pkg::t_byte gmul(aesrt_pkg::t_byte a, aesrt_pkg::t_byte b);
        aesrt_pkg::t_byte acc;
        aesrt_pkg::t_byte x;
        acc = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic aesrt_pkg::t_byte ginv(aesrt_pkg::t_byte a);
        aesrt_pkg::t_byte r;
        aesrt_pkg::t_byte p;
        r = 8'h01;
        p = a;
        for (int e = 254; e != 0; e >>= 1) begin
            if (e[0]) r = gmul(r, p);
            p = gmul(p, p);
        end
        return r;
    endfunction

    function automatic aesrt_pkg::t_byte rol8(aesrt_pkg::t_byte b, int n);
        return (b << n) | (b >> (8 - n));
    endfunction

    function automatic aesrt_pkg::t_byte sub_byte(aesrt_pkg::t_byte x);
        aesrt_pkg::t_byte b;
        b = ginv(x);
        return b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
    endfunction

    function automatic aesrt_pkg::t_byte inv_sub_byte(aesrt_pkg::t_byte y);
        return ginv(rol8(y, 1) ^ rol8(y, 3) ^ rol8(y, 6) ^ 8'h05);
    endfunction

    // Apply one command to the model state and return the new state.
    function automatic t_state_word apply_round_op(t_word w);
        aesrt_pkg::t_byte old[16];
        aesrt_pkg::t_byte col[4];
        aesrt_pkg::t_byte din[16];
        aesrt_pkg::t_byte coef[4];
        aesrt_pkg::t_byte acc;
        int               s;
        t_state_word      res;
        for (int i = 0; i < 8; i++) begin
            din[i]     = w.data_hi[63 - 8 * i -: 8];
            din[8 + i] = w.data_lo[63 - 8 * i -: 8];
        end
        old = model_state;
        case (w.command)
            aesrt_pkg::CMD_LOAD:    model_state = din;
            aesrt_pkg::CMD_ADD_KEY:
                for (int i = 0; i < 16; i++) model_state[i] ^= din[i];
            aesrt_pkg::CMD_SUB:
                for (int i = 0; i < 16; i++) model_state[i] = sub_byte(old[i]);
            aesrt_pkg::CMD_INV_SUB:
                for (int i = 0; i < 16; i++) model_state[i] = inv_sub_byte(old[i]);
            aesrt_pkg::CMD_SHIFT, aesrt_pkg::CMD_INV_SHIFT: begin
                for (int r = 0; r < 4; r++) begin
                    s = (w.command == aesrt_pkg::CMD_SHIFT) ? r : (4 - r) & 3;
                    for (int c = 0; c < 4; c++)
                        model_state[r + 4 * c] = old[r + 4 * ((c + s) & 3)];
                end
            end
            default: begin
                if (w.command == aesrt_pkg::CMD_MIX) begin
                    coef = '{8'd2, 8'd3, 8'd1, 8'd1};
                end else begin
                    coef = '{8'd14, 8'd11, 8'd13, 8'd9};
                end
                for (int c = 0; c < 4; c++) begin
                    for (int r = 0; r < 4; r++) col[r] = old[r + 4 * c];
                    for (int r = 0; r < 4; r++) begin
                        acc = 8'h00;
                        for (int k = 0; k < 4; k++) acc ^= gmul(coef[(k - r) & 3], col[k]);
                        model_state[r + 4 * c] = acc;
                    end
                end
            end
        endcase
        for (int i = 0; i < 8; i++) begin
            res.hi[63 - 8 * i -: 8] = model_state[i];
            res.lo[63 - 8 * i -: 8] = model_state[8 + i];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic void push_word(logic [2:0] c, logic [63:0] hi, logic [63:0] lo);
        t_word w;
        w.command = c;
        w.data_hi = hi;
        w.data_lo = lo;
        cmd_queue.push_back(w);
    endfunction

    // Driver: hold the word until accepted, then advance after a random gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !accepted_last) begin
            // hold
        end else if (send_gap > 0 || drain_hold || cmd_queue.size() == 0) begin
            if (send_gap > 0) send_gap--;
            i_valid <= 1'b0;
        end else begin
            t_word w;
            w = cmd_queue.pop_front();
            i_valid   <= 1'b1;
            i_command <= w.command;
            i_data_hi <= w.data_hi;
            i_data_lo <= w.data_lo;
            send_gap  = pick_gap();
        end
    end

    always @(negedge i_clk) begin
        if (recv_gap > 0) begin
            recv_gap--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 9) < 3) recv_gap = pick_gap();
        end
    end

    // Monitor and predictor on the rising edge.
    always @(posedge i_clk) begin
        t_word       w;
        t_state_word want;
        cycle_count++;
        accepted_last <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            w.command = i_command;
            w.data_hi = i_data_hi;
            w.data_lo = i_data_lo;
            expected_states.push_back(apply_round_op(w));
            cmd_hits[w.command]++;
            words_sent++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_states.size() == 0) begin
                report_mismatch("unexpected word", o_state_hi, '0);
            end else begin
                want = expected_states.pop_front();
                if (o_state_hi !== want.hi) report_mismatch("state_hi", o_state_hi, want.hi);
                if (o_state_lo !== want.lo) report_mismatch("state_lo", o_state_lo, want.lo);
                states_checked++;
            end
        end
        if (cycle_count >= CycleLimit) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int total;
        int k;
        int p;
        for (int i = 0; i < 16; i++) model_state[i] = 8'h00;
        // Directed: transforms on the reset state, then extremes and every command.
        push_word(aesrt_pkg::CMD_SUB, '1, '1);
        push_word(aesrt_pkg::CMD_INV_SUB, '0, '0);
        push_word(aesrt_pkg::CMD_LOAD, '1, '1);
        push_word(aesrt_pkg::CMD_SUB, '0, '0);
        push_word(aesrt_pkg::CMD_INV_SUB, '0, '0);
        push_word(aesrt_pkg::CMD_LOAD, 64'h00112233_44556677, 64'h8899aabb_ccddeeff);
        push_word(aesrt_pkg::CMD_ADD_KEY, 64'h00010203_04050607, 64'h08090a0b_0c0d0e0f);
        push_word(aesrt_pkg::CMD_SUB, rand64(), rand64());
        push_word(aesrt_pkg::CMD_SHIFT, rand64(), rand64());
        push_word(aesrt_pkg::CMD_MIX, rand64(), rand64());
        push_word(aesrt_pkg::CMD_INV_MIX, rand64(), rand64());
        push_word(aesrt_pkg::CMD_INV_SHIFT, rand64(), rand64());
        push_word(aesrt_pkg::CMD_INV_SUB, rand64(), rand64());
        push_word(aesrt_pkg::CMD_ADD_KEY, '1, '1);
        push_word(aesrt_pkg::CMD_MIX, '0, '0);
        push_word(aesrt_pkg::CMD_LOAD, '0, '0);
        push_word(aesrt_pkg::CMD_MIX, '0, '0);
        push_word(aesrt_pkg::CMD_ADD_KEY, '0, '1);
        push_word(aesrt_pkg::CMD_INV_MIX, '0, '0);
        total = 19;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (total < 850) begin
            p = $urandom_range(0, 9);
            if (p < 6) begin
                // well-formed round: load, then a random mix of round steps
                push_word(aesrt_pkg::CMD_LOAD, rand64(), rand64());
                k = $urandom_range(3, 12);
                for (int j = 0; j < k; j++)
                    push_word(3'($urandom_range(1, 7)), rand64(), rand64());
                total += k + 1;
            end else begin
                push_word(3'($urandom_range(0, 7)), rand64(), rand64());
                total++;
            end
            if (total > 400 && total < 420) begin
                // pause the sender until every result is back
                while (cmd_queue.size() != 0 || i_valid) @(posedge i_clk);
                drain_hold = 1'b1;
                while (expected_states.size() != 0) @(posedge i_clk);
                repeat (3) @(posedge i_clk);
                drain_hold = 1'b0;
                total = 420;
            end
        end
        while (cmd_queue.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_states.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        $display("Sent %0d words, checked %0d states", words_sent, states_checked);
        $display("Per command: %0d %0d %0d %0d %0d %0d %0d %0d", cmd_hits[0], cmd_hits[1],
                 cmd_hits[2], cmd_hits[3], cmd_hits[4], cmd_hits[5], cmd_hits[6], cmd_hits[7]);
        if (error_count == 0 && expected_states.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
